// ===== rtl/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared widths, register codes, reset values and types of the triangle
// projection and cull block.
// ----------------------------------------------------------------------------
package tpc_pkg;

    localparam int COORD_W  = 24;
    localparam int VTX_W    = 3 * COORD_W;
    localparam int SCR_W    = 12;
    localparam int DEPTH_W  = 23;
    localparam int CFG_W    = 23;
    localparam int SCALE_W  = 14;
    localparam int NUM_W    = COORD_W + SCALE_W;
    localparam int DEN_W    = DEPTH_W;
    localparam int POS_W    = NUM_W + 2;
    localparam int LANES    = 3;
    localparam int DEF_VERTEX_SLOTS = 256;

    localparam logic [SCALE_W-1:0] PROJ_SCALE = SCALE_W'(16000);

    localparam logic [SCR_W-1:0]   RST_WIDTH  = SCR_W'(800);
    localparam logic [SCR_W-1:0]   RST_HEIGHT = SCR_W'(600);
    localparam logic [DEPTH_W-1:0] RST_NEAR   = DEPTH_W'(2560);
    localparam logic [DEPTH_W-1:0] RST_FAR    = DEPTH_W'(3840000);

    typedef enum logic [1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_NEAR_DEPTH    = 2'd2,
        CFG_FAR_DEPTH     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SCR_W-1:0]   width;
        logic [SCR_W-1:0]   height;
        logic [DEPTH_W-1:0] near_d;
        logic [DEPTH_W-1:0] far_d;
    } t_cfg;

    typedef struct packed {
        logic                      ok;
        logic                      left;
        logic                      top;
        logic                      right;
        logic                      bottom;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_lane_res;

endpackage

// ===== rtl/tpc_ram.sv =====
// ----------------------------------------------------------------------------
// tpc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tpc_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tpc_div.sv =====
// ----------------------------------------------------------------------------
// tpc_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband tag that travels alongside.
// ----------------------------------------------------------------------------
module tpc_div #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 23,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic [NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic [DEN_W-1:0] r_rem  [1:NUM_W];
    logic [NUM_W-1:0] r_work [1:NUM_W];
    logic [DEN_W-1:0] r_dv   [1:NUM_W];
    logic [TAG_W-1:0] r_tag  [1:NUM_W];

    for (genvar s = 1; s <= NUM_W; s++) begin : g_stage
        logic [DEN_W-1:0] p_rem;
        logic [NUM_W-1:0] p_work;
        logic [DEN_W-1:0] p_den;
        logic [TAG_W-1:0] p_tag;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (s == 1) begin : g_first
            assign p_rem  = '0;
            assign p_work = i_num;
            assign p_den  = i_den;
            assign p_tag  = i_tag;
        end else begin : g_next
            assign p_rem  = r_rem[s-1];
            assign p_work = r_work[s-1];
            assign p_den  = r_dv[s-1];
            assign p_tag  = r_tag[s-1];
        end

        assign trial = {p_rem, p_work[NUM_W-1]};
        assign diff  = trial - {1'b0, p_den};
        assign ge    = trial >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_work[s] <= {p_work[NUM_W-2:0], ge};
                r_dv[s]   <= p_den;
                r_tag[s]  <= p_tag;
            end
        end
    end

    assign o_quo = r_work[NUM_W];
    assign o_tag = r_tag[NUM_W];

endmodule

// ===== rtl/tpc_lane.sv =====
// ----------------------------------------------------------------------------
// tpc_lane
// One triangle corner: depth test, scale, divide by depth, recenter, edge
// flags and output saturation.
// ----------------------------------------------------------------------------
module tpc_lane import tpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_adv,
    input  t_cfg             i_cfg,
    input  logic             i_in_range,
    input  logic [VTX_W-1:0] i_vtx,
    output t_lane_res        o_res
);

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [POS_W-1:0] v);
        logic signed [POS_W-1:0] hi;
        logic signed [POS_W-1:0] lo;
        hi = POS_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
        lo = -hi - POS_W'(1);
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    logic signed [COORD_W-1:0] x, y, z;
    logic [COORD_W-1:0] mag_x, mag_y;
    logic               ok;

    assign x = i_vtx[VTX_W-1 -: COORD_W];
    assign y = i_vtx[2*COORD_W-1 -: COORD_W];
    assign z = i_vtx[COORD_W-1:0];

    assign ok = i_in_range
        && ($signed({z[COORD_W-1], z}) > $signed({2'b00, i_cfg.near_d}))
        && ($signed({z[COORD_W-1], z}) <= $signed({2'b00, i_cfg.far_d}));

    assign mag_x = x[COORD_W-1] ? COORD_W'(-x) : COORD_W'(x);
    assign mag_y = y[COORD_W-1] ? COORD_W'(-y) : COORD_W'(y);

    logic [NUM_W-1:0] r_mx, r_my;
    logic [DEN_W-1:0] r_den;
    logic             r_ok, r_nx, r_ny;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mx  <= mag_x * PROJ_SCALE;
            r_my  <= mag_y * PROJ_SCALE;
            r_den <= z[DEN_W-1:0];
            r_ok  <= ok;
            r_nx  <= x[COORD_W-1];
            r_ny  <= y[COORD_W-1];
        end
    end

    logic [NUM_W-1:0] qx, qy;
    logic [1:0]       tag_x;
    logic             tag_y;

    tpc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(2)) u_div_x (
        .i_clk (i_clk),
        .i_en  (i_adv),
        .i_num (r_mx),
        .i_den (r_den),
        .i_tag ({r_ok, r_nx}),
        .o_quo (qx),
        .o_tag (tag_x)
    );

    tpc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .TAG_W(1)) u_div_y (
        .i_clk (i_clk),
        .i_en  (i_adv),
        .i_num (r_my),
        .i_den (r_den),
        .i_tag (r_ny),
        .o_quo (qy),
        .o_tag (tag_y)
    );

    logic signed [POS_W-1:0] sqx, sqy, sx, sy, cen_x, cen_y, lim_x, lim_y;
    t_lane_res               n_res;
    t_lane_res               r_res;

    always_comb begin
        sqx   = tag_x[0] ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
        sqy   = tag_y    ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
        cen_x = $signed({{(POS_W-SCR_W-3){1'b0}}, i_cfg.width[SCR_W-1:1], 4'b0});
        cen_y = $signed({{(POS_W-SCR_W-3){1'b0}}, i_cfg.height[SCR_W-1:1], 4'b0});
        lim_x = $signed({{(POS_W-SCR_W-4){1'b0}}, i_cfg.width, 4'b0});
        lim_y = $signed({{(POS_W-SCR_W-4){1'b0}}, i_cfg.height, 4'b0});
        sx    = sqx + cen_x;
        sy    = sqy + cen_y;
        n_res.ok     = tag_x[1];
        n_res.left   = sx < 0;
        n_res.top    = sy < 0;
        n_res.right  = sx >= lim_x;
        n_res.bottom = sy >= lim_y;
        n_res.px     = sat(sx);
        n_res.py     = sat(sy);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/triangle_project_and_cull.sv =====
// ----------------------------------------------------------------------------
// triangle_project_and_cull
// Vertex store, three corner lanes and the cull merge.
// ----------------------------------------------------------------------------
// Takes one item per cycle, load or triangle, with no stall of its own; only
// a held result on the output side stops the pipe. A triangle's result passes
// through registered store read, scale multiply, a 38-stage pipelined divider
// per coordinate, recenter/flag stage and merge before it comes out.
// The vertex store is held in three copies, one read port per corner, all
// written together by loads. A load to a slot is visible to a triangle
// accepted in the very next cycle. Loads give no result.
module triangle_project_and_cull import tpc_pkg::*; #(
    parameter int VERTEX_SLOTS = DEF_VERTEX_SLOTS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_op,
    input  logic [7:0]                i_vertex_slot,
    input  logic signed [COORD_W-1:0] i_vx,
    input  logic signed [COORD_W-1:0] i_vy,
    input  logic signed [COORD_W-1:0] i_vz,
    input  logic [7:0]                i_corner_a,
    input  logic [7:0]                i_corner_b,
    input  logic [7:0]                i_corner_c,
    input  logic                      i_last_triangle,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_drawn,
    output logic signed [COORD_W-1:0] o_ax,
    output logic signed [COORD_W-1:0] o_ay,
    output logic signed [COORD_W-1:0] o_bx,
    output logic signed [COORD_W-1:0] o_by,
    output logic signed [COORD_W-1:0] o_cx,
    output logic signed [COORD_W-1:0] o_cy,
    output logic                      o_batch_end,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    localparam int AW  = $clog2(VERTEX_SLOTS);
    localparam int LAT = NUM_W + 4;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.near_d <= RST_NEAR;
            r_cfg.far_d  <= RST_FAR;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SCREEN_WIDTH:  r_cfg.width  <= i_cfg_data[SCR_W-1:0];
                CFG_SCREEN_HEIGHT: r_cfg.height <= i_cfg_data[SCR_W-1:0];
                CFG_NEAR_DEPTH:    r_cfg.near_d <= i_cfg_data[DEPTH_W-1:0];
                CFG_FAR_DEPTH:     r_cfg.far_d  <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    logic adv, accept, is_load, is_tri;

    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;
    assign accept  = i_valid && adv;
    assign is_load = accept && !i_op;
    assign is_tri  = accept && i_op;

    logic [AW+7:0] slot_ext;
    logic          slot_ok;

    assign slot_ext = {{AW{1'b0}}, i_vertex_slot};
    assign slot_ok  = 32'(i_vertex_slot) < 32'(VERTEX_SLOTS);

    logic [7:0]       corner [LANES];
    logic [VTX_W-1:0] rdata  [LANES];
    logic [LANES-1:0] r_inr;
    t_lane_res        res    [LANES];

    assign corner[0] = i_corner_a;
    assign corner[1] = i_corner_b;
    assign corner[2] = i_corner_c;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < LANES; k++) begin
                r_inr[k] <= 32'(corner[k]) < 32'(VERTEX_SLOTS);
            end
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic [AW+7:0] rd_ext;

        assign rd_ext = {{AW{1'b0}}, corner[k]};

        tpc_ram #(.W(VTX_W), .D(VERTEX_SLOTS)) u_store (
            .i_clk   (i_clk),
            .i_we    (is_load && slot_ok),
            .i_waddr (slot_ext[AW-1:0]),
            .i_wdata ({i_vx, i_vy, i_vz}),
            .i_re    (adv),
            .i_raddr (rd_ext[AW-1:0]),
            .o_rdata (rdata[k])
        );

        tpc_lane u_lane (
            .i_clk      (i_clk),
            .i_adv      (adv),
            .i_cfg      (r_cfg),
            .i_in_range (r_inr[k]),
            .i_vtx      (rdata[k]),
            .o_res      (res[k])
        );
    end

    logic [LAT:1] r_vld;
    logic [LAT:1] r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-1:1], is_tri};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_last <= {r_last[LAT-1:1], i_last_triangle};
        end
    end

    logic n_drawn;

    assign n_drawn = res[0].ok && res[1].ok && res[2].ok
        && !(res[0].left   && res[1].left   && res[2].left)
        && !(res[0].top    && res[1].top    && res[2].top)
        && !(res[0].right  && res[1].right  && res[2].right)
        && !(res[0].bottom && res[1].bottom && res[2].bottom);

    logic                      r_drawn;
    logic signed [COORD_W-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_drawn <= n_drawn;
            r_ax    <= n_drawn ? res[0].px : '0;
            r_ay    <= n_drawn ? res[0].py : '0;
            r_bx    <= n_drawn ? res[1].px : '0;
            r_by    <= n_drawn ? res[1].py : '0;
            r_cx    <= n_drawn ? res[2].px : '0;
            r_cy    <= n_drawn ? res[2].py : '0;
        end
    end

    assign o_valid     = r_vld[LAT];
    assign o_drawn     = r_drawn;
    assign o_ax        = r_ax;
    assign o_ay        = r_ay;
    assign o_bx        = r_bx;
    assign o_by        = r_by;
    assign o_cx        = r_cx;
    assign o_cy        = r_cy;
    assign o_batch_end = r_last[LAT];

    a_load_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_load |=> !r_vld[1])
        else $error("load entered the result pipe");

    a_cull_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_drawn |-> o_ax == 0 && o_ay == 0 && o_bx == 0 && o_by == 0
            && o_cx == 0 && o_cy == 0)
        else $error("culled triangle carries coordinates");

    a_drawn_not_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drawn |-> !(o_ax[COORD_W-1] && o_bx[COORD_W-1] && o_cx[COORD_W-1]))
        else $error("drawn triangle lies left of screen");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipe moved during stall");

endmodule
